### hdl/s_expression_tokenizer_unit_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef S_EXPRESSION_TOKENIZER_UNIT_MACROS_SVH
`define S_EXPRESSION_TOKENIZER_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SETOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SETOK_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hdl/setok_pkg.sv
// Types, codes and character classes for the S-expression tokenizer.
package setok_pkg;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_HASH    = 4'd1,
    ST_COMMENT = 4'd2,
    ST_STRING  = 4'd3,
    ST_MINUS   = 4'd4,
    ST_INT     = 4'd5,
    ST_FRAC    = 4'd6,
    ST_IDENT   = 4'd7,
    ST_ERROR   = 4'd8
  } lex_state_e;

  typedef enum logic [3:0] {
    KIND_END    = 4'd0,
    KIND_LPAREN = 4'd1,
    KIND_RPAREN = 4'd2,
    KIND_QUOTE  = 4'd3,
    KIND_TRUE   = 4'd4,
    KIND_FALSE  = 4'd5,
    KIND_STRING = 4'd6,
    KIND_INT    = 4'd7,
    KIND_FLOAT  = 4'd8,
    KIND_IDENT  = 4'd9
  } token_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_BOOL   = 3'd1,
    ERR_UNTERM_STR = 3'd2,
    ERR_UNKNOWN    = 3'd3,
    ERR_TOO_LONG   = 3'd4
  } error_code_e;

  typedef struct packed {
    logic        last;
    error_code_e error_code;
    logic [16:0] length;
    logic [15:0] start_offset;
    token_kind_e token_kind;
  } result_t;

  // Results of one source byte, in order; cnt of them are valid.
  typedef struct packed {
    logic [1:0]        cnt;
    result_t [2:0]     item;
  } wr_bundle_t;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned QDEPTH      = 8;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_ident_char(logic [7:0] c);
    logic alnum;
    logic sym;
    alnum = is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    sym = (c == 8'h21) || (c == 8'h24) || (c == 8'h25) || (c == 8'h26) ||
          (c == 8'h2A) || (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2E) ||
          (c == 8'h2F) || (c == 8'h3A) || (c == 8'h3C) || (c == 8'h3D) ||
          (c == 8'h3E) || (c == 8'h3F) || (c == 8'h40) || (c == 8'h5E) ||
          (c == 8'h5F) || (c == 8'h7E);
    return alnum || sym;
  endfunction

endpackage

### hdl/setok_lexer.sv
// Lexer state registers and the per-byte token logic.
module setok_lexer import setok_pkg::*; #(
  parameter int unsigned MAX_SOURCE_BYTES = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       vld_i,
  input  logic [7:0] byte_i,
  input  logic       eos_i,
  output wr_bundle_t wr_o
);

  localparam int unsigned POS_W = $clog2(MAX_SOURCE_BYTES + 1);

  lex_state_e       st_q, st_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] ts_q, ts_d;

  function automatic result_t mk_res(token_kind_e k, logic [31:0] s, logic [31:0] l,
                                     error_code_e e, logic fin);
    result_t r;
    r.token_kind   = k;
    r.start_offset = s[15:0];
    r.length       = l[16:0];
    r.error_code   = e;
    r.last         = fin;
    return r;
  endfunction

  result_t          cand [4];
  logic [3:0]       cv;
  logic             relex;
  logic [POS_W-1:0] len;
  logic [POS_W-1:0] fin_len;
  logic [1:0]       n;

  always_comb begin
    st_d    = st_q;
    pos_d   = pos_q;
    ts_d    = ts_q;
    relex   = 1'b0;
    cv      = '0;
    for (int i = 0; i < 4; i++) cand[i] = '0;
    len     = pos_q - ts_q;
    fin_len = '0;

    if (st_q != ST_ERROR) begin
      if (pos_q >= POS_W'(MAX_SOURCE_BYTES)) begin
        cand[0] = mk_res(KIND_END, 32'(pos_q), 32'd0, ERR_TOO_LONG, 1'b0);
        cv[0]   = 1'b1;
        st_d    = ST_ERROR;
      end else begin
        pos_d = pos_q + POS_W'(1);
        unique case (st_q)
          ST_IDLE: relex = 1'b1;
          ST_HASH: begin
            st_d  = ST_IDLE;
            cv[0] = 1'b1;
            if (byte_i == CH_LOW_T) begin
              cand[0] = mk_res(KIND_TRUE, 32'(ts_q), 32'd2, ERR_NONE, 1'b0);
            end else if (byte_i == CH_LOW_F) begin
              cand[0] = mk_res(KIND_FALSE, 32'(ts_q), 32'd2, ERR_NONE, 1'b0);
            end else begin
              cand[0] = mk_res(KIND_END, 32'(ts_q), 32'd0, ERR_BAD_BOOL, 1'b0);
              st_d    = ST_ERROR;
            end
          end
          ST_COMMENT: begin
            if (byte_i == CH_NL) st_d = ST_IDLE;
          end
          ST_STRING: begin
            if (byte_i == CH_DQUOTE) begin
              cand[0] = mk_res(KIND_STRING, 32'(ts_q), 32'(len), ERR_NONE, 1'b0);
              cv[0]   = 1'b1;
              st_d    = ST_IDLE;
            end
          end
          ST_MINUS: begin
            priority if (is_digit(byte_i)) begin
              st_d = ST_INT;
            end else if (byte_i == CH_DOT) begin
              st_d = ST_FRAC;
            end else if (is_ident_char(byte_i)) begin
              st_d = ST_IDENT;
            end else begin
              cand[0] = mk_res(KIND_IDENT, 32'(ts_q), 32'd1, ERR_NONE, 1'b0);
              cv[0]   = 1'b1;
              relex   = 1'b1;
            end
          end
          ST_INT: begin
            priority if (is_digit(byte_i)) begin
              st_d = ST_INT;
            end else if (byte_i == CH_DOT) begin
              st_d = ST_FRAC;
            end else begin
              cand[0] = mk_res(KIND_INT, 32'(ts_q), 32'(len), ERR_NONE, 1'b0);
              cv[0]   = 1'b1;
              relex   = 1'b1;
            end
          end
          ST_FRAC: begin
            if (!is_digit(byte_i)) begin
              cand[0] = mk_res(KIND_FLOAT, 32'(ts_q), 32'(len), ERR_NONE, 1'b0);
              cv[0]   = 1'b1;
              relex   = 1'b1;
            end
          end
          ST_IDENT: begin
            if (!is_ident_char(byte_i)) begin
              cand[0] = mk_res(KIND_IDENT, 32'(ts_q), 32'(len), ERR_NONE, 1'b0);
              cv[0]   = 1'b1;
              relex   = 1'b1;
            end
          end
          ST_ERROR: ;
          default: ;
        endcase

        // Lex the byte again from idle once the pending token has closed.
        if (relex) begin
          ts_d = pos_q;
          st_d = ST_IDLE;
          priority if (is_space(byte_i)) begin
            st_d = ST_IDLE;
          end else if (byte_i == CH_LPAREN) begin
            cand[1] = mk_res(KIND_LPAREN, 32'(pos_q), 32'd1, ERR_NONE, 1'b0);
            cv[1]   = 1'b1;
          end else if (byte_i == CH_RPAREN) begin
            cand[1] = mk_res(KIND_RPAREN, 32'(pos_q), 32'd1, ERR_NONE, 1'b0);
            cv[1]   = 1'b1;
          end else if (byte_i == CH_QUOTE) begin
            cand[1] = mk_res(KIND_QUOTE, 32'(pos_q), 32'd1, ERR_NONE, 1'b0);
            cv[1]   = 1'b1;
          end else if (byte_i == CH_HASH) begin
            st_d = ST_HASH;
          end else if (byte_i == CH_SEMI) begin
            st_d = ST_COMMENT;
          end else if (byte_i == CH_DQUOTE) begin
            ts_d = pos_q + POS_W'(1);
            st_d = ST_STRING;
          end else if (is_digit(byte_i)) begin
            st_d = ST_INT;
          end else if (byte_i == CH_MINUS) begin
            st_d = ST_MINUS;
          end else if (is_ident_char(byte_i)) begin
            st_d = ST_IDENT;
          end else begin
            cand[1] = mk_res(KIND_END, 32'(pos_q), 32'd0, ERR_UNKNOWN, 1'b0);
            cv[1]   = 1'b1;
            st_d    = ST_ERROR;
          end
        end
      end
    end

    // Close the source: flush the pending token, then the end marker.
    if (eos_i) begin
      fin_len = pos_d - ts_d;
      unique case (st_d)
        ST_HASH: begin
          cand[2] = mk_res(KIND_END, 32'(ts_d), 32'd0, ERR_BAD_BOOL, 1'b0);
          cv[2]   = 1'b1;
        end
        ST_STRING: begin
          cand[2] = mk_res(KIND_END, 32'(ts_d - POS_W'(1)), 32'd0, ERR_UNTERM_STR, 1'b0);
          cv[2]   = 1'b1;
        end
        ST_MINUS: begin
          cand[2] = mk_res(KIND_IDENT, 32'(ts_d), 32'd1, ERR_NONE, 1'b0);
          cv[2]   = 1'b1;
        end
        ST_INT: begin
          cand[2] = mk_res(KIND_INT, 32'(ts_d), 32'(fin_len), ERR_NONE, 1'b0);
          cv[2]   = 1'b1;
        end
        ST_FRAC: begin
          cand[2] = mk_res(KIND_FLOAT, 32'(ts_d), 32'(fin_len), ERR_NONE, 1'b0);
          cv[2]   = 1'b1;
        end
        ST_IDENT: begin
          cand[2] = mk_res(KIND_IDENT, 32'(ts_d), 32'(fin_len), ERR_NONE, 1'b0);
          cv[2]   = 1'b1;
        end
        default: ;
      endcase
      cand[3] = mk_res(KIND_END, 32'(pos_d), 32'd0, ERR_NONE, 1'b1);
      cv[3]   = 1'b1;
      st_d    = ST_IDLE;
      pos_d   = '0;
      ts_d    = '0;
    end
  end

  // Pack the valid candidates into the first slots, in order.
  always_comb begin
    n       = '0;
    wr_o    = '0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i] && (n != 2'(MAX_RESULTS))) begin
        wr_o.item[n] = cand[i];
        n = n + 2'd1;
      end
    end
    wr_o.cnt = vld_i ? n : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      pos_q <= '0;
      ts_q  <= '0;
    end else if (vld_i) begin
      st_q  <= st_d;
      pos_q <= pos_d;
      ts_q  <= ts_d;
    end
  end

endmodule

### hdl/setok_fifo.sv
// Result queue: takes up to three results per cycle, hands out one.
module setok_fifo import setok_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wr_bundle_t        wr_i,
  input  logic              rd_i,
  output result_t           item_o,
  output logic [QCNT_W-1:0] cnt_o
);

  result_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(wr_i.cnt);
    rd_ptr_d = rd_ptr_q + QPTR_W'(rd_i);
    cnt_d    = cnt_q + QCNT_W'(wr_i.cnt) - QCNT_W'(rd_i);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < wr_i.cnt) mem_q[wr_ptr_q + QPTR_W'(i)] <= wr_i.item[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign item_o = mem_q[rd_ptr_q];
  assign cnt_o  = cnt_q;

endmodule

### hdl/s_expression_tokenizer_unit.sv
// S-expression tokenizer: one source byte a cycle in and one token a cycle out while the
// streams are ready. Source bytes enter on the slave stream, tlast on the final byte of a
// source, and pass through an input register into the lexer, which finishes one byte per cycle
// and emits zero to three results (a closed token, a single-character token or error, and at
// the end of a source the flushed token and the end marker with tlast). Results wait in an
// eight-entry queue drained at one per cycle while m_axis_tready is high; s_axis_tready drops
// when the queue could not take three more results for every byte in flight. Bytes that each
// make at most one result stream at one per cycle while the master is ready; a result goes
// through the input register and the queue to the master stream. Errors give an end-kind result
// with the error code, and bytes after an error are dropped until the final byte of the source.
`include "s_expression_tokenizer_unit_macros.svh"

module s_expression_tokenizer_unit import setok_pkg::*; #(
  parameter int unsigned MAX_SOURCE_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_req
  input  logic        s_axis_tlast,   // end_of_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [3:0] token_kind, [19:4] start_offset,
                                      // [36:20] length, [39:37] error_code
  output logic        m_axis_tlast    // last
);

  logic              in_vld_q;
  logic [7:0]        in_byte_q;
  logic              in_eos_q;
  wr_bundle_t        wr;
  result_t           head;
  logic [QCNT_W-1:0] q_cnt;
  logic              rd;
  logic [4:0]        need;

  // Reserve room for the byte in the input register and the one arriving now.
  assign need          = 5'(q_cnt) + (in_vld_q ? 5'(MAX_RESULTS) : 5'd0) + 5'(MAX_RESULTS);
  assign s_axis_tready = (need <= 5'(QDEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eos_q  <= s_axis_tlast;
    end
  end

  setok_lexer #(
    .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
  ) u_lexer (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (in_vld_q),
    .byte_i(in_byte_q),
    .eos_i (in_eos_q),
    .wr_o  (wr)
  );

  assign rd = m_axis_tvalid && m_axis_tready;

  setok_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .wr_i  (wr),
    .rd_i  (rd),
    .item_o(head),
    .cnt_o (q_cnt)
  );

  assign m_axis_tvalid = (q_cnt != '0);
  assign m_axis_tdata  = {head.error_code, head.length, head.start_offset, head.token_kind};
  assign m_axis_tlast  = head.last;

  `SETOK_NEVER(a_q_bound, q_cnt > QCNT_W'(QDEPTH), "result queue count beyond depth")
  `SETOK_NEVER(a_q_room, (5'(q_cnt) + 5'(wr.cnt)) > 5'(QDEPTH), "result queue overflow")
  `SETOK_ASSERT(a_take_byte, s_axis_tvalid && s_axis_tready |=> in_vld_q, "byte not registered")
  `SETOK_NEVER(a_idle_write, !in_vld_q && (wr.cnt != 2'd0), "results without a byte")

endmodule
